@@ rtl/afe_pkg.sv @@
// Package for the audio fade envelope: payload structs, register indexes,
// state codes and the elaboration-time curve point generator.
// No dependencies.
package afe_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int SHAPE_W   = 3;
    localparam int NUM_SHAPES = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       file_start;
    } afe_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_done;
    } afe_out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_FRAMES    = 3'd0,
        CFG_NUM_CHANNELS    = 3'd1,
        CFG_FADE_IN_FRAMES  = 3'd2,
        CFG_FADE_IN_SHAPE   = 3'd3,
        CFG_FADE_OUT_FRAMES = 3'd4,
        CFG_FADE_OUT_SHAPE  = 3'd5
    } afe_cfg_idx_t;

    localparam logic [SHAPE_W-1:0] SHAPE_LINEAR = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SCURVE = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_EXP    = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_LOG    = 3'd4;
    localparam logic [SHAPE_W-1:0] SHAPE_SQRT   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SET1, ST_SET2, ST_CSTART, ST_DIV1, ST_ROMA, ST_ROMB, ST_ROMC,
        ST_MAC, ST_DIV2, ST_CEND, ST_GEND, ST_SMSET, ST_SEND, ST_OUT
    } afe_state_t;

    typedef enum logic [1:0] {
        MAC_INTERP, MAC_GAIN, MAC_SAMPLE
    } afe_mac_t;

    localparam longint unsigned Q30          = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam longint unsigned LN2_Q30      = 64'd744261118;
    localparam longint          LOG_COEF_Q30 = 215485664;
    localparam longint          Q30S         = 64'sd1 << 30;

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint unsigned q30_to_gain(longint unsigned v, int Frac);
        longint unsigned g;
        longint unsigned one;
        g   = (v + (64'd1 << (29 - Frac))) >> (30 - Frac);
        one = 64'd1 << Frac;
        return (g > one) ? one : g;
    endfunction

    function automatic longint unsigned sin_q30(longint unsigned th);
        longint unsigned t2;
        longint unsigned r;
        t2 = (th * th) >> 30;
        r  = Q30;
        for (int k = 8; k >= 1; k--) begin
            r = Q30 - ((t2 * r) >> 30) / 64'((2 * k) * (2 * k + 1));
        end
        return (th * r) >> 30;
    endfunction

    function automatic longint log2_q30(longint unsigned n);
        longint unsigned e;
        longint unsigned m;
        longint unsigned fr;
        e  = 0;
        fr = 0;
        while ((n >> (e + 1)) != 0) e++;
        m = (n << 30) >> e;
        for (int b = 1; b <= 30; b++) begin
            m = (m * m) >> 30;
            if (m >= 2 * Q30) begin
                m  = m >> 1;
                fr = fr | (64'd1 << (30 - b));
            end
        end
        return longint'((e << 30) + fr);
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned bt;
        longint unsigned w;
        r  = 0;
        w  = v;
        bt = 64'd1 << 62;
        while (bt > w) bt = bt >> 2;
        while (bt != 0) begin
            if (w >= r + bt) begin
                w = w - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // One point of one curve at x = idx / Depth, as an unsigned Q1.Frac gain.
    function automatic longint unsigned curve_point(int shape, int idx, int Depth, int Frac);
        longint unsigned i;
        longint unsigned s;
        longint unsigned xq;
        longint unsigned yq;
        longint unsigned ip;
        longint unsigned a;
        longint unsigned r;
        longint unsigned v;
        longint          l;
        longint          lv;
        i  = 64'(idx);
        s  = sin_q30(i * HALF_PI_Q30 / 64'(Depth));
        xq = i * Q30 / 64'(Depth);
        v  = 0;
        case (SHAPE_W'(shape))
            SHAPE_LINEAR: v = ((i << Frac) + 64'(Depth) / 2) / 64'(Depth);
            SHAPE_SINE:   v = q30_to_gain(s, Frac);
            SHAPE_SCURVE: v = q30_to_gain((s * s) >> 30, Frac);
            SHAPE_EXP: begin
                yq = 5 * (64'(Depth) - i) * Q30 / 64'(Depth);
                ip = yq >> 30;
                a  = ((Q30 - (yq & (Q30 - 1))) * LN2_Q30) >> 30;
                r  = Q30;
                for (int k = 12; k >= 1; k--) begin
                    r = Q30 + ((a * r) >> 30) / 64'(k);
                end
                v = q30_to_gain(r >> (ip + 1), Frac);
            end
            SHAPE_LOG: begin
                if (idx == 0) begin
                    v = 0;
                end else begin
                    l  = log2_q30(i) - log2_q30(64'(Depth));
                    lv = Q30S + (LOG_COEF_Q30 * l) / Q30S;
                    v  = q30_to_gain((lv < 0) ? xq : longint'(lv), Frac);
                end
            end
            SHAPE_SQRT:   v = isqrt64((i << (2 * Frac)) / 64'(Depth));
            default:      v = 0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/audio_fade_envelope_unit.sv @@
// Top level of the audio fade envelope: counters, gain sequencer, curve ROM
// and a shared bit-serial multiplier and divider.
// Depends on afe_pkg.
//
// Usage: samples of one interleaved file enter on the s_ channel, one request per
// sample; file_start on the first sample clears the frame and channel counters.
// Each request yields exactly one result on the m_ channel: the sample scaled by
// the gain of its frame, with frame_done set on the last channel of a frame.
// The block works on one sample at a time. A sample that is not channel 0 is
// scaled by the bit-serial multiply.
// Channel 0 first builds the frame gain: per active fade one divide
// for the table position, two ROM reads, an interpolation multiply and
// another divide, plus one multiply when both fades overlap; a fade at
// position zero skips the divides and ROM reads.
// Results wait in an output register; a stalled receiver holds the result there,
// and the next sample is accepted and worked on, but its result waits until the
// register is taken. After reset the registers hold their reset values, the
// counters are zero and the block is idle and ready. Configuration is to be
// written only while the block is idle; the block itself does not enforce it.
module audio_fade_envelope_unit
    import afe_pkg::*;
#(
    parameter int FRAME_COUNT_BITS  = 24,
    parameter int MAX_CHANNELS      = 8,
    parameter int GAIN_FRAC_BITS    = 16,
    parameter int CURVE_TABLE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  afe_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output afe_out_t             m_data
);

    localparam int G   = GAIN_FRAC_BITS;
    localparam int FW  = FRAME_COUNT_BITS;
    localparam int D   = CURVE_TABLE_DEPTH;
    localparam int PW  = CFG_W;
    localparam int CW  = imax(FW, PW);
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int IW  = $clog2(D + 1);
    localparam int MW  = imax(PW, G + 1);
    localparam int OW  = imax(G + 1, SAMPLE_W);
    localparam int AW  = imax(imax(G + 1 + PW, PW + IW), imax(SAMPLE_W + G, 2 * G + 1)) + 1;
    localparam int CNTW = $clog2(AW + 1);
    localparam int ROM_DEPTH = NUM_SHAPES * (D + 1);
    localparam int RAW = $clog2(ROM_DEPTH);
    localparam logic [G:0]          GAIN_ONE = (G + 1)'(1) << G;
    localparam logic [AW-1:0]       GHALF    = AW'(1) << (G - 1);
    localparam logic [SAMPLE_W-1:0] SMAX     = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMIN     = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    localparam logic [FW-1:0]       FMAX     = {FW{1'b1}};

    // Curve ROM, six shapes of D+1 points each, contents fixed at elaboration.
    logic [G:0] rom_w [ROM_DEPTH];
    for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
        localparam longint unsigned PT = curve_point(k / (D + 1), k % (D + 1), D, G);
        assign rom_w[k] = (G + 1)'(PT);
    end

    // Configuration registers.
    logic [PW-1:0]      total_reg, fin_reg, fout_reg;
    logic [3:0]         nch_reg;
    logic [SHAPE_W-1:0] fish_reg, fosh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= PW'(1);
            nch_reg   <= 4'd1;
            fin_reg   <= '0;
            fish_reg  <= SHAPE_SINE;
            fout_reg  <= '0;
            fosh_reg  <= SHAPE_SINE;
        end else if (cfg_we) begin
            case (afe_cfg_idx_t'(cfg_index))
                CFG_TOTAL_FRAMES:    total_reg <= cfg_data;
                CFG_NUM_CHANNELS:    nch_reg   <= cfg_data[3:0];
                CFG_FADE_IN_FRAMES:  fin_reg   <= cfg_data;
                CFG_FADE_IN_SHAPE:   fish_reg  <= cfg_data[SHAPE_W-1:0];
                CFG_FADE_OUT_FRAMES: fout_reg  <= cfg_data;
                CFG_FADE_OUT_SHAPE:  fosh_reg  <= cfg_data[SHAPE_W-1:0];
                default: ;
            endcase
        end
    end

    afe_state_t state_reg, state_next;
    afe_mac_t   kind_reg, kind_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [FW-1:0]   frame_count_reg, frame_count_next, gf_reg, gf_next;
    logic [CHW-1:0]  channel_count_reg, channel_count_next;
    logic [G:0]      frame_gain_reg, frame_gain_next, gin_reg, gin_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next, res_reg, res_next;
    logic            done_reg, done_next, phase_reg, phase_next;
    logic            in_act_reg, in_act_next, out_act_reg, out_act_next;
    logic [PW-1:0]   last_reg, last_next, nin_reg, nin_next, start_reg, start_next;
    logic [PW-1:0]   posi_reg, posi_next, sizei_reg, sizei_next;
    logic [PW-1:0]   poso_reg, poso_next, sizeo_reg, sizeo_next;
    logic [PW-1:0]   sz_reg, sz_next, r_reg, r_next;
    logic [SHAPE_W-1:0] shape_reg, shape_next;
    logic [AW-1:0]   x_reg, x_next;
    logic [MW-1:0]   ma_reg, ma_next, mb_reg, mb_next;
    logic [OW-1:0]   opa_reg, opa_next;
    logic [G:0]      opb_reg, opb_next;
    logic [G:0]      rom_q_reg;
    logic            m_valid_reg, m_valid_next;
    afe_out_t        m_data_reg, m_data_next;

    // Shared datapath pieces.
    logic [PW:0]     dv_t;
    logic            dv_ge;
    logic [AW-1:0]   mac_sum, rnd;
    logic [RAW-1:0]  rom_addr;
    logic [4:0]      nc5, cc5;
    logic [CHW-1:0]  cc;
    logic [FW-1:0]   fc;
    logic [CW-1:0]   fcx;
    logic [PW-1:0]   tot, cpos, csize;
    logic [SAMPLE_W-1:0] mag;
    logic            out_free, accept;

    assign dv_t  = {r_reg, x_reg[AW-1]};
    assign dv_ge = dv_t >= {1'b0, sz_reg};
    assign mac_sum = (x_reg << 1) + (ma_reg[MW-1] ? AW'(opa_reg) : '0)
                   + (mb_reg[MW-1] ? AW'(opb_reg) : '0);
    assign rnd = (x_reg + GHALF) >> G;
    assign rom_addr = RAW'(shape_reg * (D + 1)) + RAW'(x_reg[IW-1:0])
                    + RAW'(state_reg == ST_ROMB);
    assign mag = sample_reg[SAMPLE_W-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign fcx = CW'(gf_reg);
    assign tot = (total_reg == '0) ? PW'(1) : total_reg;
    assign cpos  = phase_reg ? poso_reg : posi_reg;
    assign csize = phase_reg ? sizeo_reg : sizei_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign cc = s_data.file_start ? '0 : channel_count_reg;
    assign fc = s_data.file_start ? '0 : frame_count_reg;
    assign cc5 = 5'(cc) + 5'd1;

    always_comb begin
        if (nch_reg == 4'd0) begin
            nc5 = 5'd1;
        end else if ({1'b0, nch_reg} > 5'(MAX_CHANNELS)) begin
            nc5 = 5'(MAX_CHANNELS);
        end else begin
            nc5 = {1'b0, nch_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rom_q_reg <= rom_w[rom_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            frame_count_reg   <= '0;
            channel_count_reg <= '0;
            frame_gain_reg    <= '0;
            m_valid_reg       <= 1'b0;
            cnt_reg           <= '0;
            kind_reg          <= MAC_SAMPLE;
            phase_reg         <= 1'b0;
        end else begin
            state_reg         <= state_next;
            frame_count_reg   <= frame_count_next;
            channel_count_reg <= channel_count_next;
            frame_gain_reg    <= frame_gain_next;
            m_valid_reg       <= m_valid_next;
            cnt_reg           <= cnt_next;
            kind_reg          <= kind_next;
            phase_reg         <= phase_next;
        end
        gf_reg      <= gf_next;
        gin_reg     <= gin_next;
        sample_reg  <= sample_next;
        res_reg     <= res_next;
        done_reg    <= done_next;
        in_act_reg  <= in_act_next;
        out_act_reg <= out_act_next;
        last_reg    <= last_next;
        nin_reg     <= nin_next;
        start_reg   <= start_next;
        posi_reg    <= posi_next;
        sizei_reg   <= sizei_next;
        poso_reg    <= poso_next;
        sizeo_reg   <= sizeo_next;
        sz_reg      <= sz_next;
        r_reg       <= r_next;
        shape_reg   <= shape_next;
        x_reg       <= x_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        cnt_next           = cnt_reg;
        frame_count_next   = frame_count_reg;
        channel_count_next = channel_count_reg;
        frame_gain_next    = frame_gain_reg;
        gf_next            = gf_reg;
        gin_next           = gin_reg;
        sample_next        = sample_reg;
        res_next           = res_reg;
        done_next          = done_reg;
        phase_next         = phase_reg;
        in_act_next        = in_act_reg;
        out_act_next       = out_act_reg;
        last_next          = last_reg;
        nin_next           = nin_reg;
        start_next         = start_reg;
        posi_next          = posi_reg;
        sizei_next         = sizei_reg;
        poso_next          = poso_reg;
        sizeo_next         = sizeo_reg;
        sz_next            = sz_reg;
        r_next             = r_reg;
        shape_next         = shape_reg;
        x_next             = x_reg;
        ma_next            = ma_reg;
        mb_next            = mb_reg;
        opa_next           = opa_reg;
        opb_next           = opb_reg;
        m_data_next        = m_data_reg;
        m_valid_next       = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sample_next = s_data.sample_in;
                    gf_next     = fc;
                    // Counters advance now; the gain is built from the frame held in gf.
                    if (cc5 >= nc5) begin
                        done_next          = 1'b1;
                        channel_count_next = '0;
                        frame_count_next   = (fc < FMAX) ? fc + 1'b1 : fc;
                    end else begin
                        done_next          = 1'b0;
                        channel_count_next = cc + 1'b1;
                        frame_count_next   = fc;
                    end
                    state_next = (cc == '0) ? ST_SET1 : ST_SMSET;
                end
            end
            ST_SET1: begin
                last_next  = tot - 1'b1;
                nin_next   = (fin_reg < tot - 1'b1) ? fin_reg : tot - 1'b1;
                start_next = (tot - 1'b1 > fout_reg) ? tot - 1'b1 - fout_reg : '0;
                state_next = ST_SET2;
            end
            ST_SET2: begin
                in_act_next  = (fin_reg != '0) && (fcx < CW'(nin_reg));
                out_act_next = (fout_reg != '0) && (fcx > CW'(start_reg))
                            && (fcx <= CW'(last_reg));
                posi_next  = fcx[PW-1:0];
                sizei_next = nin_reg;
                poso_next  = last_reg - fcx[PW-1:0];
                sizeo_next = last_reg - start_reg;
                if ((fin_reg != '0) && (fcx < CW'(nin_reg))) begin
                    phase_next = 1'b0;
                    state_next = ST_CSTART;
                end else if ((fout_reg != '0) && (fcx > CW'(start_reg))
                             && (fcx <= CW'(last_reg))) begin
                    phase_next = 1'b1;
                    state_next = ST_CSTART;
                end else begin
                    frame_gain_next = GAIN_ONE;
                    state_next      = ST_SMSET;
                end
            end
            ST_CSTART: begin
                shape_next = phase_reg ? fosh_reg : fish_reg;
                if (shape_next >= SHAPE_W'(NUM_SHAPES)) begin
                    shape_next = SHAPE_LINEAR;
                end
                sz_next  = csize;
                r_next   = '0;
                cnt_next = '0;
                if (cpos == '0) begin
                    // Position zero of a fade is silent.
                    x_next     = '0;
                    state_next = ST_CEND;
                end else begin
                    x_next     = AW'(cpos) * AW'(D);
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2: begin
                r_next   = dv_ge ? PW'(dv_t - {1'b0, sz_reg}) : dv_t[PW-1:0];
                x_next   = {x_reg[AW-2:0], dv_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(AW - 1)) begin
                    state_next = (state_reg == ST_DIV1) ? ST_ROMA : ST_CEND;
                end
            end
            ST_ROMA: begin
                state_next = ST_ROMB;
            end
            ST_ROMB: begin
                opa_next   = OW'(rom_q_reg);
                state_next = ST_ROMC;
            end
            ST_ROMC: begin
                opb_next   = rom_q_reg;
                ma_next    = MW'(sz_reg - r_reg);
                mb_next    = MW'(r_reg);
                x_next     = '0;
                cnt_next   = '0;
                kind_next  = MAC_INTERP;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                x_next   = mac_sum;
                ma_next  = ma_reg << 1;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(MW - 1)) begin
                    cnt_next = '0;
                    r_next   = '0;
                    case (kind_reg)
                        MAC_INTERP: state_next = ST_DIV2;
                        MAC_GAIN:   state_next = ST_GEND;
                        MAC_SAMPLE: state_next = ST_SEND;
                        default:    state_next = ST_SEND;
                    endcase
                end
            end
            ST_CEND: begin
                if (!phase_reg) begin
                    gin_next = x_reg[G:0];
                    if (out_act_reg) begin
                        phase_next = 1'b1;
                        state_next = ST_CSTART;
                    end else begin
                        frame_gain_next = x_reg[G:0];
                        state_next      = ST_SMSET;
                    end
                end else if (in_act_reg) begin
                    // Overlapping fades: multiply the two gains.
                    opa_next   = OW'(gin_reg);
                    ma_next    = MW'(x_reg[G:0]);
                    mb_next    = '0;
                    x_next     = '0;
                    cnt_next   = '0;
                    kind_next  = MAC_GAIN;
                    state_next = ST_MAC;
                end else begin
                    frame_gain_next = x_reg[G:0];
                    state_next      = ST_SMSET;
                end
            end
            ST_GEND: begin
                frame_gain_next = rnd[G:0];
                state_next      = ST_SMSET;
            end
            ST_SMSET: begin
                opa_next   = OW'(mag);
                ma_next    = MW'(frame_gain_reg);
                mb_next    = '0;
                x_next     = '0;
                cnt_next   = '0;
                kind_next  = MAC_SAMPLE;
                state_next = ST_MAC;
            end
            ST_SEND: begin
                if (!sample_reg[SAMPLE_W-1]) begin
                    res_next = (rnd > AW'(SMAX)) ? SMAX : rnd[SAMPLE_W-1:0];
                end else begin
                    res_next = (rnd > AW'(SMIN)) ? SMIN : (~rnd[SAMPLE_W-1:0] + 1'b1);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_next.sample_out = res_reg;
                    m_data_next.frame_done = done_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is still in work");

    a_channel_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(channel_count_reg) < MAX_CHANNELS)
        else $error("channel counter out of range");

    a_gain_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SMSET |-> frame_gain_reg <= GAIN_ONE)
        else $error("frame gain above one");

    a_index_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROMA |-> x_reg < AW'(D))
        else $error("curve table index out of range");
`endif

endmodule
